// ----- rtl/ptpc_pkg.sv -----
package ptpc_pkg;

  // Request codes carried in the low bits of s_tuser.
  localparam logic [2:0] OP_DEG2POS  = 3'd0;
  localparam logic [2:0] OP_POS2DEG  = 3'd1;
  localparam logic [2:0] OP_CODE2POS = 3'd2;
  localparam logic [2:0] OP_POS2CODE = 3'd3;
  localparam logic [2:0] OP_ORDER    = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_COORD_TYPE = 1'b0;
  localparam logic CFG_IMAGE_FLIP = 1'b1;

  localparam int ValueAW = 33;
  localparam int ValueBW = 20;
  localparam int ResultW = 21;
  localparam int ClampW  = 18;

  // Degree scale per coordinate type and half of it for rounding.
  localparam logic [11:0] BASE_T0 = 12'd2359;
  localparam logic [11:0] BASE_T1 = 12'd512;
  localparam logic [20:0] HALF_T0 = 21'd1179;
  localparam logic [20:0] HALF_T1 = 21'd256;

  // Reciprocals for exact division of narrow magnitudes.
  localparam logic [20:0] RECIP_10   = 21'd838861;   // ceil(2^23 / 10)
  localparam logic [20:0] RECIP_2359 = 21'd1820673;  // ceil(2^32 / 2359)

  localparam logic [16:0] DEG_IN_SAT = 17'h1FFFF;
  localparam logic [19:0] POS_SAT    = 20'hFFFFF;

  localparam logic [20:0] NO_LIMIT_T0 = 21'h07FFFF;
  localparam logic [20:0] NO_LIMIT_T1 = 21'h007FFF;

  typedef struct packed {
    logic [ResultW-1:0] value;
    logic               ok;
  } direct_t;

  function automatic logic signed [ClampW-1:0] lim_lo(input logic deg, input logic tilt,
                                                      input logic t, input logic f);
    logic signed [ClampW-1:0] v;
    if (deg) begin
      if (!tilt)   v = t ? -18'sd170 : -18'sd170;
      else if (!t) v = f ? -18'sd210 : -18'sd30;
      else         v = f ? -18'sd90 : -18'sd20;
    end else begin
      if (!tilt)   v = t ? -18'sd8704 : -18'sd40103;
      else if (!t) v = f ? -18'sd49539 : -18'sd7077;
      else         v = f ? -18'sd4608 : -18'sd1024;
    end
    return v;
  endfunction

  function automatic logic signed [ClampW-1:0] lim_hi(input logic deg, input logic tilt,
                                                      input logic t, input logic f);
    logic signed [ClampW-1:0] v;
    if (deg) begin
      if (!tilt)   v = 18'sd170;
      else if (!t) v = f ? 18'sd15 : 18'sd195;
      else         v = f ? 18'sd20 : 18'sd90;
    end else begin
      if (!tilt)   v = t ? 18'sd8704 : 18'sd40103;
      else if (!t) v = f ? 18'sd3538 : 18'sd46000;
      else         v = f ? 18'sd1024 : 18'sd4608;
    end
    return v;
  endfunction

endpackage

// ----- rtl/ptpc_direct.sv -----
module ptpc_direct import ptpc_pkg::*; (
  input  logic [2:0]         op,
  input  logic               axis,
  input  logic [ValueAW-1:0] value_a,
  input  logic [ValueBW-1:0] value_b,
  input  logic               coord_type,
  output direct_t            result
);

  logic        hi_bits;
  logic [19:0] code;
  logic [20:0] no_limit;
  logic [19:0] rel_max;
  logic [20:0] code2pos;
  logic signed [ValueAW-1:0] a_s;
  logic signed [ValueAW-1:0] b_s;
  logic        a_gt_b;
  logic        b_gt_a;

  always_comb begin
    if (coord_type) begin
      hi_bits  = |value_a[32:16];
      code     = {4'd0, value_a[15:0]};
      no_limit = NO_LIMIT_T1;
      rel_max  = axis ? 20'h01600 : 20'h04400;
    end else begin
      hi_bits  = |value_a[32:20];
      code     = value_a[19:0];
      no_limit = NO_LIMIT_T0;
      rel_max  = axis ? 20'h0CF56 : 20'h1394E;
    end
  end

  // Codes above the relative maximum wrap to negative positions.
  always_comb begin
    if (hi_bits || (value_a == 33'(no_limit))) begin
      code2pos = no_limit;
    end else if (code > rel_max) begin
      code2pos = coord_type ? {5'b11111, code[15:0]} : {1'b1, code};
    end else begin
      code2pos = {1'b0, code};
    end
  end

  assign a_s    = $signed(value_a);
  assign b_s    = 33'($signed(value_b));
  assign a_gt_b = a_s > b_s;
  assign b_gt_a = b_s > a_s;

  always_comb begin
    result = '0;
    case (op)
      OP_CODE2POS: result.value = code2pos;
      OP_POS2CODE: result.value = {1'b0, code};
      OP_ORDER:    result.ok = (!axis && coord_type) ? b_gt_a : a_gt_b;
      default:     result = '0;
    endcase
  end

endmodule

// ----- rtl/pan_tilt_position_converter_core.sv -----
// Pan/tilt position converter, four register stages deep.
// A request passes through the stage 1, stage 2, stage 3 and output registers, and
// one request can be accepted every cycle; stages hold while the output waits.
// A reciprocal multiply performs the constant division.
// Reset (synchronous, rst high) empties the pipeline and sets coord_type and
// image_flip to zero.
module pan_tilt_position_converter_core import ptpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic        cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // value_a[32:0], value_b[52:33], zero pad
  input  logic [3:0]  s_tuser,   // req_type[2:0], axis[3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // result_value[20:0], order_ok[21], zero pad
);

  logic coord_type;
  logic image_flip;

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_type <= 1'b0;
      image_flip <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_COORD_TYPE: coord_type <= cfg_wdata;
        CFG_IMAGE_FLIP: image_flip <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline occupancy and flow control.
  logic v1, v2, v3, vout;
  logic rdy1, rdy2, rdy3, rdy_out;

  assign rdy_out  = !vout || m_tready;
  assign rdy3     = !v3 || rdy_out;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  // No request is taken while reset is held.
  assign s_tready = rdy1 && !rst;
  assign m_tvalid = vout;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      vout <= 1'b0;
    end else begin
      if (rdy1)    v1   <= s_tvalid;
      if (rdy2)    v2   <= v1;
      if (rdy3)    v3   <= v2;
      if (rdy_out) vout <= v3;
    end
  end

  // Stage 1: input register.
  logic [2:0]         op1;
  logic               axis1;
  logic [ValueAW-1:0] a1;
  logic [ValueBW-1:0] b1;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1   <= s_tuser[2:0];
      axis1 <= s_tuser[3];
      a1    <= s_tdata[32:0];
      b1    <= s_tdata[52:33];
    end
  end

  // Stage 1 -> 2: scale product, rounded numerator, direct results.
  logic signed [45:0] prod_next;
  logic signed [12:0] base_s;
  logic [32:0]        amag;
  logic [16:0]        amag_sat;
  logic [20:0]        num_next;
  direct_t            direct_next;

  assign base_s    = $signed({1'b0, coord_type ? BASE_T1 : BASE_T0});
  assign prod_next = 46'($signed(a1)) * 46'(base_s);
  assign amag      = a1[32] ? (~a1 + 33'd1) : a1;
  // Large inputs saturate; their quotient still lands beyond every clamp.
  assign amag_sat  = (amag > 33'(DEG_IN_SAT)) ? DEG_IN_SAT : amag[16:0];
  assign num_next  = ({4'd0, amag_sat} << 3) + ({4'd0, amag_sat} << 1)
                   + (coord_type ? HALF_T1 : HALF_T0);

  ptpc_direct u_direct (
    .op         (op1),
    .axis       (axis1),
    .value_a    (a1),
    .value_b    (b1),
    .coord_type (coord_type),
    .result     (direct_next)
  );

  logic [2:0]         op2;
  logic               axis2;
  logic signed [45:0] prod2;
  logic               neg_a2;
  logic [20:0]        num2;
  direct_t            direct2;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      op2     <= op1;
      axis2   <= axis1;
      prod2   <= prod_next;
      neg_a2  <= a1[32];
      num2    <= num_next;
      direct2 <= direct_next;
    end
  end

  // Stage 2 -> 3: divide magnitudes by a constant through a reciprocal multiply (a shift for type 1 pos-to-deg).
  logic [45:0] pmag;
  logic [19:0] psat;
  logic [20:0] mul_x;
  logic [20:0] mul_k;
  logic [41:0] mul_p;
  logic [16:0] quo_next;
  logic        neg_next;

  assign pmag  = prod2[45] ? 46'(-prod2) : 46'(prod2);
  assign psat  = (pmag > 46'(POS_SAT)) ? POS_SAT : pmag[19:0];
  assign mul_x = (op2 == OP_DEG2POS) ? {1'b0, psat} : num2;
  assign mul_k = (op2 == OP_DEG2POS) ? RECIP_10 : RECIP_2359;
  assign mul_p = 42'(mul_x) * 42'(mul_k);

  always_comb begin
    if (op2 == OP_DEG2POS) begin
      quo_next = mul_p[39:23];
      neg_next = prod2[45];
    end else begin
      quo_next = coord_type ? 17'(num2[20:9]) : 17'(mul_p[41:32]);
      neg_next = neg_a2;
    end
  end

  logic [2:0]  op3;
  logic        axis3;
  logic [16:0] quo3;
  logic        neg3;
  direct_t     direct3;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      op3     <= op2;
      axis3   <= axis2;
      quo3    <= quo_next;
      neg3    <= neg_next;
      direct3 <= direct2;
    end
  end

  // Stage 3 -> output: restore the sign, clamp, select.
  logic signed [ClampW-1:0] sval;
  logic signed [ClampW-1:0] lo;
  logic signed [ClampW-1:0] hi;
  logic signed [ClampW-1:0] clamped;
  logic                     is_deg;
  direct_t                  out_next;

  assign sval   = neg3 ? -$signed({1'b0, quo3}) : $signed({1'b0, quo3});
  assign is_deg = (op3 == OP_POS2DEG);
  assign lo     = lim_lo(is_deg, axis3, coord_type, image_flip);
  assign hi     = lim_hi(is_deg, axis3, coord_type, image_flip);

  always_comb begin
    if (sval < lo)      clamped = lo;
    else if (sval > hi) clamped = hi;
    else                clamped = sval;
  end

  always_comb begin
    case (op3)
      OP_DEG2POS, OP_POS2DEG: begin
        out_next.value = ResultW'(clamped);
        out_next.ok    = 1'b0;
      end
      default: out_next = direct3;
    endcase
  end

  direct_t out_q;

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_q <= out_next;
    end
  end

  assign m_tdata = {2'b00, out_q.ok, out_q.value};

endmodule
